/* src/fit_policy_block_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Fit policy block allocator assertion macros
// Concurrent assertion wrappers, removed when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define FPBA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpba assertion failed");
// next-cycle implication
`define FPBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpba assertion failed");
`else
`define FPBA_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define FPBA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* src/fpba_pkg.sv */
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared constants, codes and types of the fit policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

   localparam int NUM_BLOCKS_DEF = 8;
   localparam int SIZE_BITS_DEF  = 16;

   localparam int CMD_W      = 1;
   localparam int IDX_W      = 3;
   localparam int AMT_W      = 16;
   localparam int MODE_W     = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

   // register index, taken from csr address bit 2
   localparam logic REG_FIT_MODE = 1'b0;

   typedef enum logic [MODE_W-1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2
   } fit_mode_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   typedef struct packed {
      logic             granted;
      logic [IDX_W-1:0] chosen_block;
      logic [AMT_W-1:0] left_over;
   } result_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctrl_type;

endpackage

/* src/fit_policy_block_allocator.sv */
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Free size table with first, best and worst fit block allocation.
// ----------------------------------------------------------------------------
// The block keeps one remaining free size per memory block, all zero after
// reset. A load transaction (command 0) writes one block's size and returns
// granted 0 with the index echoed; an allocate transaction (command 1) scans
// every block through one shared comparator under the policy in fit_mode
// (first, best or worst fit, ties to the lowest index), takes the request off
// the chosen block and returns that block and its new size, or all zeros when
// no block fits. One transaction is worked on at a time: an allocation holds
// the sequencer through the scan, write and done states until it can take the
// next one, a load through the done state; the table has a single read port,
// which the scan walks one entry a cycle. A finished result waits in the
// output register, so the next transaction is taken while it is unclaimed.
// Write fit_mode only while the block is idle.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator #(
   parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
   parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [fpba_pkg::CMD_W-1:0]      req_command,
   input  logic [fpba_pkg::IDX_W-1:0]      req_block_index,
   input  logic [fpba_pkg::AMT_W-1:0]      req_amount,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_granted,
   output logic [fpba_pkg::IDX_W-1:0]      rsp_chosen_block,
   output logic [fpba_pkg::AMT_W-1:0]      rsp_left_over,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fpba_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fpba_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fpba_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int ADDR_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int MODE_W = fpba_pkg::MODE_W;

   logic [MODE_W-1:0]      fit_mode_ff, fit_mode_in;
   logic                   csr_wr;
   logic                   rsp_valid_ff, rsp_valid_in;
   fpba_pkg::result_type   rsp_ff, rsp_in;

   fpba_pkg::mem_ctrl_type mem_ctrl;
   logic [ADDR_W-1:0]      wr_addr;
   logic [SIZE_BITS-1:0]   wr_data;
   logic [ADDR_W-1:0]      rd_addr;
   logic [SIZE_BITS-1:0]   rd_data;
   logic                   res_valid;
   logic                   res_take;
   fpba_pkg::result_type   result;

   // ---- register port: zero wait states, write on the access phase ----
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      fit_mode_in = fit_mode_ff;
      // low address bits are ignored: any byte of the word hits the register
      if (csr_wr && (csr_paddr[2] == fpba_pkg::REG_FIT_MODE)) begin
         fit_mode_in = csr_pwdata[MODE_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == fpba_pkg::REG_FIT_MODE) begin
         csr_prdata = {{(fpba_pkg::CSR_DATA_W - MODE_W){1'b0}}, fit_mode_ff};
      end
   end

   // ---- output register: take a result whenever the slot frees up ----
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         // drop the transaction the consumer has just taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff  <= fpba_pkg::FIT_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         fit_mode_ff  <= fit_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the payload while the consumer stalls
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_ff.granted;
   assign rsp_chosen_block = rsp_ff.chosen_block;
   assign rsp_left_over    = rsp_ff.left_over;

   // ---- sequencer with the shared compare unit ----
   fpba_seq #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS),
      .ADDR_W     (ADDR_W)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_block_index (req_block_index),
      .req_amount      (req_amount),
      .fit_mode        (fit_mode_ff),
      .mem_ctrl        (mem_ctrl),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .res_valid       (res_valid),
      .res_take        (res_take),
      .result          (result)
   );

   // ---- free size table ----
   fpba_table #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS),
      .ADDR_W     (ADDR_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .mem_ctrl (mem_ctrl),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

endmodule

/* src/fpba_table.sv */
// ----------------------------------------------------------------------------
// fpba_table
// Free size table: one write port, one registered read port, valid bits.
// ----------------------------------------------------------------------------
module fpba_table #(
   parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
   parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF,
   parameter int ADDR_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fpba_pkg::mem_ctrl_type mem_ctrl,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  logic [SIZE_BITS-1:0]   wr_data,
   input  logic [ADDR_W-1:0]      rd_addr,
   output logic [SIZE_BITS-1:0]   rd_data
);

   logic [SIZE_BITS-1:0]  mem_ff [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] valid_ff;
   logic [NUM_BLOCKS-1:0] valid_in;
   logic [SIZE_BITS-1:0]  rd_q_ff;
   logic                  rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (mem_ctrl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctrl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctrl.rd_en) begin
         rd_q_ff     <= mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // unwritten entries read as empty
   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

/* src/fpba_cmp.sv */
// ----------------------------------------------------------------------------
// fpba_cmp
// Shared compare unit: decides whether a candidate block replaces the pick.
// ----------------------------------------------------------------------------
module fpba_cmp #(
   parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF
) (
   input  logic [SIZE_BITS-1:0]        cand_size,
   input  logic [SIZE_BITS-1:0]        need,
   input  logic [SIZE_BITS-1:0]        pick_size,
   input  logic                        found,
   input  logic [fpba_pkg::MODE_W-1:0] fit_mode,
   output logic                        take
);

   logic fits;
   logic better;

   assign fits = (cand_size >= need);

   // strict order keeps ties on the lowest index
   always_comb begin
      case (fit_mode)
         fpba_pkg::FIT_BEST:  better = (cand_size < pick_size);
         fpba_pkg::FIT_WORST: better = (cand_size > pick_size);
         default:             better = 1'b0;
      endcase
   end

   assign take = fits && (!found || better);

endmodule

/* src/fpba_seq.sv */
// ----------------------------------------------------------------------------
// fpba_seq
// Sequencer: loads, table scan through the compare unit, write-back.
// ----------------------------------------------------------------------------
`include "fit_policy_block_allocator_macros.svh"

module fpba_seq #(
   parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
   parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF,
   parameter int ADDR_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [fpba_pkg::CMD_W-1:0]  req_command,
   input  logic [fpba_pkg::IDX_W-1:0]  req_block_index,
   input  logic [fpba_pkg::AMT_W-1:0]  req_amount,
   input  logic [fpba_pkg::MODE_W-1:0] fit_mode,
   output fpba_pkg::mem_ctrl_type      mem_ctrl,
   output logic [ADDR_W-1:0]           wr_addr,
   output logic [SIZE_BITS-1:0]        wr_data,
   output logic [ADDR_W-1:0]           rd_addr,
   input  logic [SIZE_BITS-1:0]        rd_data,
   output logic                        res_valid,
   input  logic                        res_take,
   output fpba_pkg::result_type        result
);

   localparam int IDX_W = fpba_pkg::IDX_W;
   localparam int AMT_W = fpba_pkg::AMT_W;
   localparam logic [ADDR_W-1:0] LAST = ADDR_W'(NUM_BLOCKS - 1);

   fpba_pkg::state_type  state_ff, state_in;
   logic [ADDR_W-1:0]    ptr_ff, ptr_in;
   logic                 issue_ff, issue_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [ADDR_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [SIZE_BITS-1:0] need_ff, need_in;
   logic                 found_ff, found_in;
   logic [ADDR_W-1:0]    pick_idx_ff, pick_idx_in;
   logic [SIZE_BITS-1:0] pick_size_ff, pick_size_in;
   fpba_pkg::result_type res_ff, res_in;

   logic                       take;
   logic                       in_range;
   logic [AMT_W+SIZE_BITS-1:0] amt_ext;
   logic [SIZE_BITS-1:0]       amt_sz;
   logic [IDX_W+ADDR_W-1:0]    idx_ext;
   logic [ADDR_W-1:0]          load_addr;
   logic [SIZE_BITS+AMT_W-1:0] load_left_ext;
   logic [SIZE_BITS-1:0]       diff;
   logic [SIZE_BITS+AMT_W-1:0] diff_ext;
   logic [ADDR_W+IDX_W-1:0]    pick_ext;

   // resize between the port widths and the table width
   assign amt_ext       = {{SIZE_BITS{1'b0}}, req_amount};
   assign amt_sz        = amt_ext[SIZE_BITS-1:0];
   assign idx_ext       = {{ADDR_W{1'b0}}, req_block_index};
   assign load_addr     = idx_ext[ADDR_W-1:0];
   assign in_range      = (int'(req_block_index) < NUM_BLOCKS);
   assign load_left_ext = {{AMT_W{1'b0}}, amt_sz};
   assign diff          = pick_size_ff - need_ff;
   assign diff_ext      = {{AMT_W{1'b0}}, diff};
   assign pick_ext      = {{IDX_W{1'b0}}, pick_idx_ff};

   fpba_cmp #(
      .SIZE_BITS (SIZE_BITS)
   ) u_cmp (
      .cand_size (rd_data),
      .need      (need_ff),
      .pick_size (pick_size_ff),
      .found     (found_ff),
      .fit_mode  (fit_mode),
      .take      (take)
   );

   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      issue_in       = issue_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = ptr_ff;
      need_in        = need_ff;
      found_in       = found_ff;
      pick_idx_in    = pick_idx_ff;
      pick_size_in   = pick_size_ff;
      res_in         = res_ff;
      mem_ctrl.wr_en = 1'b0;
      mem_ctrl.rd_en = 1'b0;
      wr_addr        = pick_idx_ff;
      wr_data        = diff;
      rd_addr        = ptr_ff;
      req_ready      = 1'b0;
      res_valid      = 1'b0;

      unique case (state_ff)
         fpba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == fpba_pkg::CMD_LOAD) begin
                  mem_ctrl.wr_en      = in_range;
                  wr_addr             = load_addr;
                  wr_data             = amt_sz;
                  res_in.granted      = 1'b0;
                  res_in.chosen_block = req_block_index;
                  res_in.left_over    = in_range ? load_left_ext[AMT_W-1:0] : '0;
                  state_in            = fpba_pkg::ST_DONE;
               end else begin
                  need_in  = amt_sz;
                  found_in = 1'b0;
                  ptr_in   = '0;
                  issue_in = 1'b1;
                  state_in = fpba_pkg::ST_SCAN;
               end
            end
         end
         fpba_pkg::ST_SCAN: begin
            // issue one read a cycle, compare the entry read the cycle before
            mem_ctrl.rd_en = issue_ff;
            cmp_vld_in     = issue_ff;
            if (issue_ff) begin
               if (ptr_ff == LAST) begin
                  issue_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + ADDR_W'(1);
               end
            end
            if (cmp_vld_ff) begin
               if (take) begin
                  found_in     = 1'b1;
                  pick_idx_in  = cmp_idx_ff;
                  pick_size_in = rd_data;
               end
               if (cmp_idx_ff == LAST) begin
                  state_in = fpba_pkg::ST_WRITE;
               end
            end
         end
         fpba_pkg::ST_WRITE: begin
            if (found_ff) begin
               mem_ctrl.wr_en      = 1'b1;
               res_in.granted      = 1'b1;
               res_in.chosen_block = pick_ext[IDX_W-1:0];
               res_in.left_over    = diff_ext[AMT_W-1:0];
            end else begin
               res_in = '0;
            end
            state_in = fpba_pkg::ST_DONE;
         end
         fpba_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = fpba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fpba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= fpba_pkg::ST_IDLE;
         issue_ff   <= 1'b0;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         issue_ff   <= issue_in;
         cmp_vld_ff <= cmp_vld_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      cmp_idx_ff   <= cmp_idx_in;
      need_ff      <= need_in;
      pick_idx_ff  <= pick_idx_in;
      pick_size_ff <= pick_size_in;
      res_ff       <= res_in;
   end

   assign result = res_ff;

   `FPBA_ASSERT_IMPL(a_no_write_in_scan, clock, reset,
      state_ff == fpba_pkg::ST_SCAN, !mem_ctrl.wr_en)
   `FPBA_ASSERT_NEXT(a_scan_ends_in_write, clock, reset,
      state_ff == fpba_pkg::ST_SCAN && cmp_vld_ff && cmp_idx_ff == LAST,
      state_ff == fpba_pkg::ST_WRITE)
   `FPBA_ASSERT_IMPL(a_pick_fits, clock, reset,
      state_ff == fpba_pkg::ST_WRITE && found_ff, pick_size_ff >= need_ff)
   `FPBA_ASSERT_NEXT(a_done_to_idle, clock, reset,
      state_ff == fpba_pkg::ST_DONE && res_take, state_ff == fpba_pkg::ST_IDLE)

endmodule

/* tb/tb_fit_policy_block_allocator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fit_policy_block_allocator
// Self-checking bench for the first, best and worst fit block allocator.
// ----------------------------------------------------------------------------
// A short table of directed rows runs first. It covers an allocation on the
// empty table after reset, an unsatisfiable request, zero and full-scale
// sizes, ties under best and worst fit, and the unused policy code. Rows
// whose answer is obvious carry it typed in. Every other row is checked
// against a local model of the free size table.
// Randomised phases follow, one per policy setting: mostly loads and
// allocations sized to hit real blocks, with a few extremes mixed in. Both
// handshakes idle at random, except in one quiet phase.
// ----------------------------------------------------------------------------
module tb_fit_policy_block_allocator;

   localparam int NUM_BLOCKS    = fpba_pkg::NUM_BLOCKS_DEF;
   localparam int SIZE_BITS     = fpba_pkg::SIZE_BITS_DEF;
   localparam int CMD_W         = fpba_pkg::CMD_W;
   localparam int IDX_W         = fpba_pkg::IDX_W;
   localparam int AMT_W         = fpba_pkg::AMT_W;
   localparam int MODE_W        = fpba_pkg::MODE_W;
   localparam int CSR_ADDR_W    = fpba_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W    = fpba_pkg::CSR_DATA_W;
   localparam int DRAIN_CYCLES  = NUM_BLOCKS + 8;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_ITEMS   = 100;
   localparam int QUIET_PHASE   = 3;
   localparam int MAX_REPORTS   = 10;
   localparam int DIRECTED_ROWS = 24;

   localparam logic [CMD_W-1:0]  CMD_LOAD  = fpba_pkg::CMD_LOAD;
   localparam logic [CMD_W-1:0]  CMD_ALLOC = fpba_pkg::CMD_ALLOC;
   localparam logic [MODE_W-1:0] FIT_FIRST = fpba_pkg::FIT_FIRST;
   localparam logic [MODE_W-1:0] FIT_BEST  = fpba_pkg::FIT_BEST;
   localparam logic [MODE_W-1:0] FIT_WORST = fpba_pkg::FIT_WORST;

   typedef fpba_pkg::result_type result_type;

   // the policy register is the only one; it sits at byte address 0
   localparam logic [CSR_ADDR_W-1:0] ADDR_FIT_MODE = {fpba_pkg::REG_FIT_MODE, 2'b00};
   // spare policy code, which the block must treat as first fit
   localparam logic [MODE_W-1:0]     MODE_UNUSED   = 2'd3;
   localparam result_type            NO_GRANT      = '{1'b0, 3'd0, 16'd0};

   typedef enum logic { ROW_ITEM, ROW_MODE } row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [MODE_W-1:0] mode;
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] idx;
      logic [AMT_W-1:0] amt;
      logic             fixed;
      result_type       want;
   } plan_row_type;

   // Directed rows. The block contents are noted where a row depends on them.
   plan_row_type directed_plan [DIRECTED_ROWS] = '{
      // empty table after reset: a zero request fits block 0, one unit fits none
      '{ROW_ITEM, FIT_FIRST, CMD_ALLOC, 3'd0, 16'd0,      1'b1, '{1'b1, 3'd0, 16'd0}},
      '{ROW_ITEM, FIT_FIRST, CMD_ALLOC, 3'd5, 16'd1,      1'b1, NO_GRANT},
      '{ROW_ITEM, FIT_FIRST, CMD_LOAD,  3'd7, 16'hFFFF,   1'b1, '{1'b0, 3'd7, 16'hFFFF}},
      '{ROW_ITEM, FIT_FIRST, CMD_LOAD,  3'd0, 16'd0,      1'b1, '{1'b0, 3'd0, 16'd0}},
      '{ROW_ITEM, FIT_FIRST, CMD_LOAD,  3'd3, 16'd100,    1'b1, '{1'b0, 3'd3, 16'd100}},
      '{ROW_ITEM, FIT_FIRST, CMD_LOAD,  3'd5, 16'd300,    1'b1, '{1'b0, 3'd5, 16'd300}},
      // full-scale request empties block 7 exactly
      '{ROW_ITEM, FIT_FIRST, CMD_ALLOC, 3'd0, 16'hFFFF,   1'b1, '{1'b1, 3'd7, 16'd0}},
      '{ROW_ITEM, FIT_FIRST, CMD_ALLOC, 3'd2, 16'd50,     1'b0, NO_GRANT},
      '{ROW_ITEM, FIT_FIRST, CMD_ALLOC, 3'd0, 16'd1000,   1'b1, NO_GRANT},
      '{ROW_MODE, FIT_BEST,  CMD_LOAD,  3'd0, 16'd0,      1'b0, NO_GRANT},
      '{ROW_ITEM, FIT_FIRST, CMD_LOAD,  3'd1, 16'd40,     1'b0, NO_GRANT},
      '{ROW_ITEM, FIT_FIRST, CMD_LOAD,  3'd2, 16'd500,    1'b0, NO_GRANT},
      '{ROW_ITEM, FIT_FIRST, CMD_ALLOC, 3'd0, 16'd30,     1'b0, NO_GRANT},
      // zero request under best fit lands on an empty block
      '{ROW_ITEM, FIT_FIRST, CMD_ALLOC, 3'd0, 16'd0,      1'b0, NO_GRANT},
      // blocks 3 and 4 both hold 50: the tie goes to block 3
      '{ROW_ITEM, FIT_FIRST, CMD_LOAD,  3'd4, 16'd50,     1'b0, NO_GRANT},
      '{ROW_ITEM, FIT_FIRST, CMD_ALLOC, 3'd0, 16'd45,     1'b0, NO_GRANT},
      '{ROW_MODE, FIT_WORST, CMD_LOAD,  3'd0, 16'd0,      1'b0, NO_GRANT},
      '{ROW_ITEM, FIT_FIRST, CMD_ALLOC, 3'd0, 16'd100,    1'b0, NO_GRANT},
      // blocks 2 and 6 both hold 400: worst fit takes block 2
      '{ROW_ITEM, FIT_FIRST, CMD_LOAD,  3'd6, 16'd400,    1'b0, NO_GRANT},
      '{ROW_ITEM, FIT_FIRST, CMD_ALLOC, 3'd0, 16'd10,     1'b0, NO_GRANT},
      '{ROW_ITEM, FIT_FIRST, CMD_ALLOC, 3'd0, 16'hFFFF,   1'b1, NO_GRANT},
      '{ROW_MODE, MODE_UNUSED, CMD_LOAD, 3'd0, 16'd0,     1'b0, NO_GRANT},
      '{ROW_ITEM, FIT_FIRST, CMD_ALLOC, 3'd0, 16'd200,    1'b0, NO_GRANT},
      '{ROW_MODE, FIT_FIRST, CMD_LOAD,  3'd0, 16'd0,      1'b0, NO_GRANT}
   };

   logic [MODE_W-1:0] phase_modes [RANDOM_PHASES] = '{
      FIT_BEST, FIT_WORST, MODE_UNUSED, FIT_FIRST, FIT_WORST, FIT_BEST, FIT_FIRST
   };

   // DUT ports; the inputs are all driven to known values from time zero
   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_command      = CMD_LOAD;
   logic [IDX_W-1:0]      req_block_index  = '0;
   logic [AMT_W-1:0]      req_amount       = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic                  rsp_granted;
   logic [IDX_W-1:0]      rsp_chosen_block;
   logic [AMT_W-1:0]      rsp_left_over;
   logic                  csr_psel         = 1'b0;
   logic                  csr_penable      = 1'b0;
   logic                  csr_pwrite       = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr        = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata       = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // typed-in answer travelling alongside the transaction on the request side
   logic                  req_fixed        = 1'b0;
   result_type            req_fixed_want   = '0;

   // local copy of the block's state
   logic [SIZE_BITS-1:0]  free_left [NUM_BLOCKS] = '{default: '0};
   logic [MODE_W-1:0]     policy      = FIT_FIRST;

   result_type            pending_results [$];
   int unsigned           items_sent   = 0;
   int unsigned           results_seen = 0;
   int unsigned           mismatches   = 0;
   logic                  quiet_link   = 1'b0;

   fit_policy_block_allocator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_block_index  (req_block_index),
      .req_amount       (req_amount),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted      (rsp_granted),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_left_over    (rsp_left_over),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 0;
   end

   // Apply one transaction to the local table and return what the block owes.
   // Loads overwrite a block; allocations scan the blocks under the policy,
   // keep the lowest index on ties and take the request off the winner.
   function automatic result_type place_request(logic [CMD_W-1:0] cmd,
                                                logic [IDX_W-1:0] idx,
                                                logic [AMT_W-1:0] amt);
      result_type res;
      logic       found;
      int         pick;
      res   = NO_GRANT;
      found = 1'b0;
      pick  = 0;
      if (cmd == CMD_LOAD) begin
         if (int'(idx) < NUM_BLOCKS) begin
            free_left[idx] = amt;
            res.left_over  = amt;
         end
         res.chosen_block = idx;
      end else begin
         for (int j = 0; j < NUM_BLOCKS; j++) begin
            if (free_left[j] >= amt) begin
               if (!found) begin
                  found = 1'b1;
                  pick  = j;
                  // first fit (and the spare code) stops at the first hit
                  if (policy != FIT_BEST && policy != FIT_WORST) break;
               end else if (policy == FIT_BEST && free_left[j] < free_left[pick]) begin
                  pick = j;
               end else if (policy == FIT_WORST && free_left[j] > free_left[pick]) begin
                  pick = j;
               end
            end
         end
         if (found) begin
            free_left[pick]  = free_left[pick] - amt;
            res.granted      = 1'b1;
            res.chosen_block = IDX_W'(pick);
            res.left_over    = free_left[pick];
         end
      end
      return res;
   endfunction

   function automatic void note_mismatch(string what, result_type want, result_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s: granted/block/left expected %0d/%0d/%0d, got %0d/%0d/%0d",
                  $realtime, what, want.granted, want.chosen_block, want.left_over,
                  got.granted, got.chosen_block, got.left_over);
   endfunction

   // Receiver: drop ready at random, about a fifth of the time, never in the quiet phase.
   always @(posedge clock) begin
      rsp_ready <= !reset && (quiet_link || $urandom_range(0, 99) >= 20);
   end

   // Watch both channels. Retire a result before booking a new transaction, so
   // a result can never be matched against a transaction taken at the same edge.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_granted, rsp_chosen_block, rsp_left_over};
            results_seen++;
            if (pending_results.size() == 0) begin
               note_mismatch("result with nothing outstanding", NO_GRANT, got);
            end else begin
               want = pending_results.pop_front();
               if (got.granted !== want.granted || got.chosen_block !== want.chosen_block ||
                   got.left_over !== want.left_over)
                  note_mismatch("result mismatch", want, got);
            end
         end
         if (req_valid && req_ready) begin
            want = place_request(req_command, req_block_index, req_amount);
            if (req_fixed) want = req_fixed_want;
            pending_results.push_back(want);
         end
      end
   end

   // Offer one transaction and hold it until the block takes it. Valid is
   // lowered only for an idle gap, so it is never dropped and raised in one step.
   task automatic send_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                            logic [AMT_W-1:0] amt, logic fixed, result_type want);
      if (!quiet_link && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_block_index <= idx;
      req_amount      <= amt;
      req_fixed       <= fixed;
      req_fixed_want  <= want;
      do @(posedge clock); while (!(req_valid && req_ready));
      items_sent++;
   endtask

   // Stop offering, wait for every owed result, then let the sequencer settle.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (results_seen < items_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Change the policy only with the block idle: setup cycle, then access cycle.
   task automatic write_fit_mode(logic [MODE_W-1:0] value);
      settle_block();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_FIT_MODE;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      policy       = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] idx;
      logic [AMT_W-1:0] amt;
      int unsigned      roll;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_plan[r].kind == ROW_MODE)
            write_fit_mode(directed_plan[r].mode);
         else
            send_item(directed_plan[r].cmd, directed_plan[r].idx, directed_plan[r].amt,
                      directed_plan[r].fixed, directed_plan[r].want);
      end

      // random part: one phase per policy setting
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_fit_mode(phase_modes[p]);
         quiet_link = (p == QUIET_PHASE);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            idx  = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 30) begin
               cmd = CMD_LOAD;
               // a few shared sizes make ties between blocks likely
               if (roll < 15)      amt = ($urandom_range(0, 1) != 0) ? 16'd100 : 16'd200;
               else if (roll < 25) amt = '0;
               else if (roll < 35) amt = '1;
               else                amt = AMT_W'($urandom());
            end else begin
               cmd = CMD_ALLOC;
               // mostly requests sized to fit, some exact, some hopeless
               if (roll < 10)      amt = '0;
               else if (roll < 15) amt = '1;
               else if (roll < 35) amt = free_left[$urandom_range(0, NUM_BLOCKS - 1)];
               else if (roll < 45) amt = AMT_W'($urandom());
               else                amt = AMT_W'($urandom_range(1, 2000));
            end
            send_item(cmd, idx, amt, 1'b0, NO_GRANT);
         end
         quiet_link = 1'b0;
      end

      settle_block();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("tb_fit_policy_block_allocator passed");
      end else begin
         $display("tb_fit_policy_block_allocator failed");
      end
      $finish;
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #400000;
      $display("tb_fit_policy_block_allocator failed");
      $finish;
   end

endmodule

/* fit_policy_block_allocator.f */
+incdir+src
src/fpba_pkg.sv
src/fpba_table.sv
src/fpba_cmp.sv
src/fpba_seq.sv
src/fit_policy_block_allocator.sv
tb/tb_fit_policy_block_allocator.sv
